// ===== rtl/core/cfsp_pkg.sv =====
// Shared types and constants of the class file stream parser.
package cfsp_pkg;

    localparam logic [31:0] MAGIC_WORD = 32'hCAFE_BABE;

    // Token kinds
    localparam logic [4:0] KIND_MAGIC       = 5'd0;
    localparam logic [4:0] KIND_MINOR       = 5'd1;
    localparam logic [4:0] KIND_MAJOR       = 5'd2;
    localparam logic [4:0] KIND_POOL_COUNT  = 5'd3;
    localparam logic [4:0] KIND_POOL_TAG    = 5'd4;
    localparam logic [4:0] KIND_POOL_IDX1   = 5'd5;
    localparam logic [4:0] KIND_POOL_IDX2   = 5'd6;
    localparam logic [4:0] KIND_UTF8_LEN    = 5'd7;
    localparam logic [4:0] KIND_UTF8_BYTE   = 5'd8;
    localparam logic [4:0] KIND_ACCESS      = 5'd9;
    localparam logic [4:0] KIND_THIS        = 5'd10;
    localparam logic [4:0] KIND_SUPER       = 5'd11;
    localparam logic [4:0] KIND_IFACES      = 5'd12;
    localparam logic [4:0] KIND_FIELDS      = 5'd13;
    localparam logic [4:0] KIND_METHODS     = 5'd14;
    localparam logic [4:0] KIND_M_ACCESS    = 5'd15;
    localparam logic [4:0] KIND_M_NAME      = 5'd16;
    localparam logic [4:0] KIND_M_DESC      = 5'd17;
    localparam logic [4:0] KIND_ATTR_COUNT  = 5'd18;
    localparam logic [4:0] KIND_ATTR_NAME   = 5'd19;
    localparam logic [4:0] KIND_ATTR_LEN    = 5'd20;
    localparam logic [4:0] KIND_ATTR_BYTE   = 5'd21;
    localparam logic [4:0] KIND_STATUS      = 5'd22;

    // Pool tags
    localparam logic [31:0] TAG_UTF8        = 32'd1;
    localparam logic [31:0] TAG_CLASS       = 32'd7;
    localparam logic [31:0] TAG_METHODREF   = 32'd10;
    localparam logic [31:0] TAG_NAMEANDTYPE = 32'd12;

    // Status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_TRUNCATED = 2'd1;
    localparam logic [1:0] ST_BAD_MAGIC = 2'd2;
    localparam logic [1:0] ST_NOT_IMPL  = 2'd3;

    typedef struct packed {
        logic [4:0]  kind;
        logic [31:0] value;
        logic [1:0]  status;
        logic        final_flag;
    } t_result;

endpackage

// ===== rtl/core/class_file_stream_parser.sv =====
// Streaming class file parser: byte walker and result queue.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one byte of a class file
//   per transaction, with i_end_of_file high on the final byte. Output
//   channel (o_out_valid / i_out_ready) carries result transactions: one
//   token per completed field or text/body byte, and one closing status
//   transaction (kind 22, o_final_result high) for the final byte.
//   A byte's results enter the result queue register when it is accepted.
//   Throughput: one byte per cycle unless the queue fills. The parser state
//   updates in a single pass of short logic per byte; results go into a
//   4-entry queue, and a byte is taken whenever the queue has room for two
//   results. A final byte that also completes a field yields two results.
//   Receiver stall: the queue fills and o_in_ready drops; nothing is lost.
//   Reset (i_rst_n low, synchronous): parser back to the magic phase, status
//   ok, queue emptied. After each final byte the parser also returns to
//   that state, ready for the next file.
module class_file_stream_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_file,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [4:0]  o_token_kind,
    output logic [31:0] o_token_value,
    output logic [1:0]  o_parse_status,
    output logic        o_final_result
);

    typedef enum logic [4:0] {
        PH_MAGIC, PH_MINOR, PH_MAJOR, PH_PCOUNT, PH_TAG, PH_CLASSIDX,
        PH_REF1, PH_REF2, PH_ULEN, PH_UBYTE, PH_ACCESS, PH_THIS, PH_SUPER,
        PH_IFACES, PH_FIELDS, PH_METHODS, PH_MACC, PH_MNAME, PH_MDESC,
        PH_MACNT, PH_ANAME, PH_ALEN, PH_ABODY, PH_CACNT, PH_DONE
    } t_phase;

    // Bytes per field in each phase
    function automatic logic [2:0] phase_width(input t_phase ph);
        logic [2:0] w;
        case (ph)
            PH_MAGIC, PH_ALEN:           w = 3'd4;
            PH_TAG, PH_UBYTE, PH_ABODY:  w = 3'd1;
            default:                     w = 3'd2;
        endcase
        return w;
    endfunction

    // Parser state
    t_phase      r_phase,       n_phase;
    logic [3:0]  r_byte_count,  n_byte_count;
    logic [31:0] r_shift,       n_shift;
    logic [15:0] r_pool_left,   n_pool_left;
    logic [15:0] r_methods_left, n_methods_left;
    logic [15:0] r_attrs_left,  n_attrs_left;
    logic [31:0] r_body_left,   n_body_left;
    logic [1:0]  r_status,      n_status;
    logic        r_finished,    n_finished;

    // Result queue
    cfsp_pkg::t_result r_q [4];
    logic [1:0]  r_head, r_tail;
    logic [2:0]  r_count;

    logic              in_acc, out_acc;
    logic              tok, fin;
    cfsp_pkg::t_result tok_res, fin_res;
    logic [31:0]       sh;
    logic [3:0]        cnt;
    logic [31:0]       v;
    logic [15:0]       pool_dec;
    logic [1:0]        fin_st;

    assign in_acc     = i_in_valid && o_in_ready;
    assign o_in_ready = (r_count <= 3'd2);
    assign o_out_valid = (r_count != 3'd0);
    assign out_acc    = o_out_valid && i_out_ready;

    assign o_token_kind   = r_q[r_head].kind;
    assign o_token_value  = r_q[r_head].value;
    assign o_parse_status = r_q[r_head].status;
    assign o_final_result = r_q[r_head].final_flag;

    always_comb begin
        n_phase        = r_phase;
        n_byte_count   = r_byte_count;
        n_shift        = r_shift;
        n_pool_left    = r_pool_left;
        n_methods_left = r_methods_left;
        n_attrs_left   = r_attrs_left;
        n_body_left    = r_body_left;
        n_status       = r_status;
        n_finished     = r_finished;
        tok            = 1'b0;
        fin            = 1'b0;
        tok_res        = '0;
        fin_res        = '0;
        sh             = {r_shift[23:0], i_data_byte};
        cnt            = r_byte_count + 4'd1;
        v              = sh;
        pool_dec       = r_pool_left - 16'd1;
        fin_st         = cfsp_pkg::ST_OK;

        if (in_acc && r_status == cfsp_pkg::ST_OK && !r_finished
                && r_phase != PH_DONE) begin
            if (cnt < {1'b0, phase_width(r_phase)}) begin
                n_shift      = sh;
                n_byte_count = cnt;
            end else begin
                n_shift       = '0;
                n_byte_count  = '0;
                tok           = 1'b1;
                tok_res.value = v;
                case (r_phase)
                    PH_MAGIC: begin
                        tok_res.kind = cfsp_pkg::KIND_MAGIC;
                        // mismatch flag parked in the pool counter
                        n_pool_left  = {15'd0, v != cfsp_pkg::MAGIC_WORD};
                        n_phase      = PH_MINOR;
                    end
                    PH_MINOR: begin
                        tok_res.kind = cfsp_pkg::KIND_MINOR;
                        n_phase      = PH_MAJOR;
                    end
                    PH_MAJOR: begin
                        tok_res.kind = cfsp_pkg::KIND_MAJOR;
                        n_phase      = PH_PCOUNT;
                    end
                    PH_PCOUNT: begin
                        tok_res.kind = cfsp_pkg::KIND_POOL_COUNT;
                        if (r_pool_left != 16'd0) begin
                            n_status = cfsp_pkg::ST_BAD_MAGIC;
                        end else begin
                            n_pool_left = v[15:0] - 16'd1;
                            n_phase = (v[15:0] == 16'd1) ? PH_ACCESS : PH_TAG;
                        end
                    end
                    PH_TAG: begin
                        tok_res.kind = cfsp_pkg::KIND_POOL_TAG;
                        if (v == cfsp_pkg::TAG_UTF8) begin
                            n_phase = PH_ULEN;
                        end else if (v == cfsp_pkg::TAG_CLASS) begin
                            n_phase = PH_CLASSIDX;
                        end else if (v == cfsp_pkg::TAG_METHODREF
                                || v == cfsp_pkg::TAG_NAMEANDTYPE) begin
                            n_phase = PH_REF1;
                        end else begin
                            n_status = cfsp_pkg::ST_TRUNCATED;
                        end
                    end
                    PH_CLASSIDX: begin
                        tok_res.kind = cfsp_pkg::KIND_POOL_IDX1;
                        n_pool_left  = pool_dec;
                        n_phase = (pool_dec == 16'd0) ? PH_ACCESS : PH_TAG;
                    end
                    PH_REF1: begin
                        tok_res.kind = cfsp_pkg::KIND_POOL_IDX1;
                        n_phase      = PH_REF2;
                    end
                    PH_REF2: begin
                        tok_res.kind = cfsp_pkg::KIND_POOL_IDX2;
                        n_pool_left  = pool_dec;
                        n_phase = (pool_dec == 16'd0) ? PH_ACCESS : PH_TAG;
                    end
                    PH_ULEN: begin
                        tok_res.kind = cfsp_pkg::KIND_UTF8_LEN;
                        n_body_left  = v;
                        if (v == 32'd0) begin
                            n_pool_left = pool_dec;
                            n_phase = (pool_dec == 16'd0) ? PH_ACCESS : PH_TAG;
                        end else begin
                            n_phase = PH_UBYTE;
                        end
                    end
                    PH_UBYTE: begin
                        tok_res.kind = cfsp_pkg::KIND_UTF8_BYTE;
                        n_body_left  = r_body_left - 32'd1;
                        if (r_body_left == 32'd1) begin
                            n_pool_left = pool_dec;
                            n_phase = (pool_dec == 16'd0) ? PH_ACCESS : PH_TAG;
                        end
                    end
                    PH_ACCESS: begin
                        tok_res.kind = cfsp_pkg::KIND_ACCESS;
                        n_phase      = PH_THIS;
                    end
                    PH_THIS: begin
                        tok_res.kind = cfsp_pkg::KIND_THIS;
                        n_phase      = PH_SUPER;
                    end
                    PH_SUPER: begin
                        tok_res.kind = cfsp_pkg::KIND_SUPER;
                        n_phase      = PH_IFACES;
                    end
                    PH_IFACES: begin
                        tok_res.kind = cfsp_pkg::KIND_IFACES;
                        if (v != 32'd0) n_status = cfsp_pkg::ST_NOT_IMPL;
                        else            n_phase  = PH_FIELDS;
                    end
                    PH_FIELDS: begin
                        tok_res.kind = cfsp_pkg::KIND_FIELDS;
                        if (v != 32'd0) n_status = cfsp_pkg::ST_NOT_IMPL;
                        else            n_phase  = PH_METHODS;
                    end
                    PH_METHODS: begin
                        tok_res.kind   = cfsp_pkg::KIND_METHODS;
                        n_methods_left = v[15:0];
                        n_phase = (v == 32'd0) ? PH_CACNT : PH_MACC;
                    end
                    PH_MACC: begin
                        tok_res.kind = cfsp_pkg::KIND_M_ACCESS;
                        n_phase      = PH_MNAME;
                    end
                    PH_MNAME: begin
                        tok_res.kind = cfsp_pkg::KIND_M_NAME;
                        n_phase      = PH_MDESC;
                    end
                    PH_MDESC: begin
                        tok_res.kind = cfsp_pkg::KIND_M_DESC;
                        n_phase      = PH_MACNT;
                    end
                    PH_MACNT: begin
                        tok_res.kind = cfsp_pkg::KIND_ATTR_COUNT;
                        n_attrs_left = v[15:0];
                        if (v == 32'd0) begin
                            n_methods_left = r_methods_left - 16'd1;
                            n_phase = (r_methods_left == 16'd1) ? PH_CACNT : PH_MACC;
                        end else begin
                            n_phase = PH_ANAME;
                        end
                    end
                    PH_ANAME: begin
                        tok_res.kind = cfsp_pkg::KIND_ATTR_NAME;
                        n_phase      = PH_ALEN;
                    end
                    PH_ALEN, PH_ABODY: begin
                        if (r_phase == PH_ALEN) begin
                            tok_res.kind = cfsp_pkg::KIND_ATTR_LEN;
                            n_body_left  = v;
                            n_phase      = PH_ABODY;
                        end else begin
                            tok_res.kind = cfsp_pkg::KIND_ATTR_BYTE;
                            n_body_left  = r_body_left - 32'd1;
                        end
                        // attribute complete: step attribute, then method, or finish the file
                        if ((r_phase == PH_ALEN && v == 32'd0)
                                || (r_phase == PH_ABODY && r_body_left == 32'd1)) begin
                            n_attrs_left = r_attrs_left - 16'd1;
                            if (r_attrs_left != 16'd1) begin
                                n_phase = PH_ANAME;
                            end else if (r_methods_left != 16'd0) begin
                                n_methods_left = r_methods_left - 16'd1;
                                n_phase = (r_methods_left == 16'd1) ? PH_CACNT : PH_MACC;
                            end else begin
                                n_finished = 1'b1;
                                n_phase    = PH_DONE;
                            end
                        end
                    end
                    PH_CACNT: begin
                        tok_res.kind = cfsp_pkg::KIND_ATTR_COUNT;
                        n_attrs_left = v[15:0];
                        if (v == 32'd0) begin
                            n_finished = 1'b1;
                            n_phase    = PH_DONE;
                        end else begin
                            n_phase = PH_ANAME;
                        end
                    end
                    default: begin
                        tok = 1'b0;
                    end
                endcase
            end
        end

        tok_res.status     = n_status;
        tok_res.final_flag = 1'b0;

        if (in_acc && i_end_of_file) begin
            fin_st = n_status;
            if (n_status == cfsp_pkg::ST_OK && !n_finished)
                fin_st = cfsp_pkg::ST_TRUNCATED;
            fin                = 1'b1;
            fin_res.kind       = cfsp_pkg::KIND_STATUS;
            fin_res.value      = '0;
            fin_res.status     = fin_st;
            fin_res.final_flag = 1'b1;
            // back to the start state for the next file
            n_phase        = PH_MAGIC;
            n_byte_count   = '0;
            n_shift        = '0;
            n_pool_left    = '0;
            n_methods_left = '0;
            n_attrs_left   = '0;
            n_body_left    = '0;
            n_status       = cfsp_pkg::ST_OK;
            n_finished     = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_MAGIC;
            r_byte_count   <= '0;
            r_shift        <= '0;
            r_pool_left    <= '0;
            r_methods_left <= '0;
            r_attrs_left   <= '0;
            r_body_left    <= '0;
            r_status       <= cfsp_pkg::ST_OK;
            r_finished     <= 1'b0;
            r_head         <= '0;
            r_tail         <= '0;
            r_count        <= '0;
        end else begin
            r_phase        <= n_phase;
            r_byte_count   <= n_byte_count;
            r_shift        <= n_shift;
            r_pool_left    <= n_pool_left;
            r_methods_left <= n_methods_left;
            r_attrs_left   <= n_attrs_left;
            r_body_left    <= n_body_left;
            r_status       <= n_status;
            r_finished     <= n_finished;
            r_head         <= r_head + {1'b0, out_acc};
            r_tail         <= r_tail + {1'b0, tok} + {1'b0, fin};
            r_count        <= r_count + {2'd0, tok} + {2'd0, fin} - {2'd0, out_acc};
            // queue payload only, never cleared
            if (tok) r_q[r_tail] <= tok_res;
            if (fin) r_q[r_tail + {1'b0, tok}] <= fin_res;
        end
    end

    // Assertions
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 3'd4)
        else $error("result queue overfilled");

    a_final_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_final_result) |->
            (o_token_kind == cfsp_pkg::KIND_STATUS && o_token_value == 32'd0))
        else $error("closing result malformed");

    a_eof_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_end_of_file) |=>
            (r_phase == PH_MAGIC && r_status == cfsp_pkg::ST_OK && !r_finished))
        else $error("parser not restarted after final byte");

    a_done_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_finished == (r_phase == PH_DONE))
        else $error("finished flag out of step with phase");

endmodule
